// ===== hdl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// calibration register indexes
	typedef enum logic [2:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

	localparam int RAW_W   = 24;
	localparam int CAL_W   = 16;
	localparam int OUT_W   = 32;
	localparam int DT_W    = RAW_W + 1;        // D2 - C5*256
	localparam int PROD_W  = DT_W + CAL_W + 1;  // dT * Cx, signed
	localparam int SQDT_W  = 2 * DT_W;          // dT * dT
	localparam int TM_W    = PROD_W - 23;       // TEMP - 2000
	localparam int TP_W    = TM_W + 1;          // TEMP + 1500
	localparam int TEMP_W  = TP_W + 1;
	localparam int T2_W    = SQDT_W - 1 - 31;
	localparam int SQ_W    = 2 * TP_W;
	localparam int OFF_W   = 44;
	localparam int SENS_W  = 40;
	localparam int SLO_W   = 20;                // low part of SENS for the split multiply
	localparam int SHI_W   = SENS_W - SLO_W;
	localparam int PLO_W   = RAW_W + SLO_W;
	localparam int PHI_W   = RAW_W + 1 + SHI_W;
	localparam int PP_W    = 64;

	localparam int TEMP_REF    = 2000;
	localparam int COLD_OFFSET = 3500;          // 2000 + 1500

	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} cal_t;

	// first-order terms
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp1;
		logic signed [TP_W-1:0]   tp;
		logic signed [TM_W-1:0]   tm;
		logic [T2_W-1:0]          t2;
		logic signed [OFF_W-1:0]  off1;
		logic signed [SENS_W-1:0] sens1;
	} first_t;

	// corrected terms
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} corr_t;

endpackage

// ===== hdl/bsc_front.sv =====
// ----------------------------------------------------------------------------
// bsc_front
// dT, the four dT products and the first-order TEMP, OFF and SENS terms.
// ----------------------------------------------------------------------------
module bsc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bsc_pkg::cal_t             cal,
	input  logic                      in_valid,
	output logic                      in_en,
	input  logic [bsc_pkg::RAW_W-1:0] d1,
	input  logic [bsc_pkg::RAW_W-1:0] d2,
	output logic                      out_valid,
	input  logic                      out_en,
	output bsc_pkg::first_t           out_data
);
	import bsc_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic en_s1, en_s2, en_s3;

	logic [RAW_W-1:0]         d1_s1, d1_s2;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [PROD_W-1:0] pt_s2, poff_s2, psens_s2;
	logic signed [SQDT_W-1:0] psq_s2;
	first_t                   data_s3;

	logic signed [DT_W-1:0]   dt_c;
	logic signed [TM_W-1:0]   tm_c;
	logic signed [CAL_W:0]    c3s, c4s, c6s;

	// a stage loads when empty or when its successor takes its item
	assign en_s3 = !valid_s3 || out_en;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_en = en_s1;

	assign dt_c = $signed({1'b0, d2}) - $signed({1'b0, cal.c5, 8'd0});
	assign c3s  = $signed({1'b0, cal.c3});
	assign c4s  = $signed({1'b0, cal.c4});
	assign c6s  = $signed({1'b0, cal.c6});
	assign tm_c = pt_s2[PROD_W-1:23];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d1_s1 <= d1;
			dt_s1 <= dt_c;
		end
		if (en_s2) begin
			d1_s2    <= d1_s1;
			pt_s2    <= dt_s1 * c6s;
			poff_s2  <= dt_s1 * c4s;
			psens_s2 <= dt_s1 * c3s;
			psq_s2   <= dt_s1 * dt_s1;
		end
		if (en_s3) begin
			data_s3.d1    <= d1_s2;
			data_s3.tm    <= tm_c;
			data_s3.temp1 <= TEMP_W'(tm_c + TEMP_REF);
			data_s3.tp    <= TP_W'(tm_c + COLD_OFFSET);
			data_s3.t2    <= psq_s2[SQDT_W-2:31];
			data_s3.off1  <= OFF_W'($signed({1'b0, cal.c2, 17'd0}) + (poff_s2 >>> 6));
			data_s3.sens1 <= SENS_W'($signed({1'b0, cal.c1, 16'd0}) + (psens_s2 >>> 7));
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ===== hdl/bsc_corr.sv =====
// ----------------------------------------------------------------------------
// bsc_corr
// Second-order correction below 20 C, with the extra cold term below -15 C.
// ----------------------------------------------------------------------------
module bsc_corr (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_en,
	input  bsc_pkg::first_t in_data,
	output logic            out_valid,
	input  logic            out_en,
	output bsc_pkg::corr_t  out_data
);
	import bsc_pkg::*;

	logic valid_s4, valid_s5;
	logic en_s4, en_s5;

	logic [RAW_W-1:0]         d1_s4;
	logic signed [TEMP_W-1:0] temp1_s4;
	logic [T2_W-1:0]          t2_s4;
	logic signed [OFF_W-1:0]  off1_s4;
	logic signed [SENS_W-1:0] sens1_s4;
	logic signed [SQ_W-1:0]   tm2_s4, tp2_s4;
	logic                     warm_s4, cold_s4;
	corr_t                    data_s5;

	logic signed [OFF_W-1:0]  tm2x, tp2x, off2, sens2;
	logic signed [OFF_W-1:0]  off_c;
	logic signed [OFF_W-1:0]  sens_c;
	logic signed [TEMP_W-1:0] temp_c;

	assign en_s5 = !valid_s5 || out_en;
	assign en_s4 = !valid_s4 || en_s5;
	assign in_en = en_s4;

	always_comb begin
		tm2x  = OFF_W'(tm2_s4);
		tp2x  = OFF_W'(tp2_s4);
		// 61 * tm^2 >> 4, squares are never negative
		off2  = ((tm2x <<< 6) - (tm2x <<< 2) + tm2x) >>> 4;
		sens2 = tm2x <<< 1;
		if (cold_s4) begin
			off2  = off2 + ((tp2x <<< 4) - tp2x);
			sens2 = sens2 + (tp2x <<< 3);
		end
		off_c  = off1_s4;
		sens_c = OFF_W'(sens1_s4);
		temp_c = temp1_s4;
		if (!warm_s4) begin
			off_c  = off_c - off2;
			sens_c = sens_c - sens2;
			temp_c = temp_c - $signed({1'b0, t2_s4});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s4) valid_s4 <= in_valid;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			d1_s4    <= in_data.d1;
			temp1_s4 <= in_data.temp1;
			t2_s4    <= in_data.t2;
			off1_s4  <= in_data.off1;
			sens1_s4 <= in_data.sens1;
			tm2_s4   <= in_data.tm * in_data.tm;
			tp2_s4   <= in_data.tp * in_data.tp;
			warm_s4  <= !in_data.tm[TM_W-1];
			cold_s4  <= in_data.tp[TP_W-1];
		end
		if (en_s5) begin
			data_s5.d1   <= d1_s4;
			data_s5.temp <= temp_c;
			data_s5.off  <= off_c;
			data_s5.sens <= SENS_W'(sens_c);
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = data_s5;

endmodule

// ===== hdl/bsc_press.sv =====
// ----------------------------------------------------------------------------
// bsc_press
// D1 * SENS as two partial products, then the offset and final shifts.
// ----------------------------------------------------------------------------
module bsc_press (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_en,
	input  bsc_pkg::corr_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_en,
	output logic signed [bsc_pkg::OUT_W-1:0] pressure,
	output logic signed [bsc_pkg::OUT_W-1:0] temperature
);
	import bsc_pkg::*;

	logic valid_s6, valid_s7, valid_s8;
	logic en_s6, en_s7, en_s8;

	logic [PLO_W-1:0]         plo_s6;
	logic signed [PHI_W-1:0]  phi_s6;
	logic signed [TEMP_W-1:0] temp_s6, temp_s7;
	logic signed [OFF_W-1:0]  off_s6, off_s7;
	logic signed [PP_W-1:0]   prod_s7;
	logic signed [OUT_W-1:0]  press_s8, temp_s8;

	logic signed [PP_W-1:0]   diff;

	assign en_s8 = !valid_s8 || out_en;
	assign en_s7 = !valid_s7 || en_s8;
	assign en_s6 = !valid_s6 || en_s7;
	assign in_en = en_s6;

	assign diff = (prod_s7 >>> 21) - PP_W'(off_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en_s6) valid_s6 <= in_valid;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			plo_s6  <= in_data.d1 * in_data.sens[SLO_W-1:0];
			phi_s6  <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[SENS_W-1:SLO_W]);
			temp_s6 <= in_data.temp;
			off_s6  <= in_data.off;
		end
		if (en_s7) begin
			prod_s7 <= (PP_W'(phi_s6) <<< SLO_W) + $signed({{(PP_W-PLO_W){1'b0}}, plo_s6});
			temp_s7 <= temp_s6;
			off_s7  <= off_s6;
		end
		if (en_s8) begin
			press_s8 <= OUT_W'(diff >>> 15);
			temp_s8  <= OUT_W'(temp_s7);
		end
	end

	assign out_valid   = valid_s8;
	assign pressure    = press_s8;
	assign temperature = temp_s8;

endmodule

// ===== hdl/barometer_second_order_compensation_core.sv =====
// ----------------------------------------------------------------------------
// barometer_second_order_compensation_core
// Raw D1/D2 conversions to pressure in Pa and temperature in 0.01 C.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six calibration words C1..C6 through cfg_we/cfg_index/cfg_data
//   (index 0..5, higher indexes ignored) while no item is in flight.
//   Each sample item (raw_pressure, raw_temperature) is taken when
//   sample_valid is high and sample_stall low; its result item appears on
//   pressure_pa/temperature_centi with result_valid and leaves when
//   result_stall is low.
//   Each item passes through eight registered pipeline stages; while
//   result_stall is low, throughput is one item per cycle, as each stage
//   (dT products, squares, split D1*SENS product) takes a new item each cycle.
//   When the receiver stalls, each full stage holds while empty stages
//   ahead of it keep filling, so sample_stall rises only once the whole
//   pipeline is full; nothing is lost or repeated.
//   Reset clears the calibration words to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module barometer_second_order_compensation_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [bsc_pkg::CAL_W-1:0]        cfg_data,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  logic [bsc_pkg::RAW_W-1:0]        raw_pressure,
	input  logic [bsc_pkg::RAW_W-1:0]        raw_temperature,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [bsc_pkg::OUT_W-1:0] pressure_pa,
	output logic signed [bsc_pkg::OUT_W-1:0] temperature_centi
);
	import bsc_pkg::*;

	cal_t   cal_q;
	logic   front_en, corr_en, press_en;
	logic   front_valid, corr_valid;
	first_t front_data;
	corr_t  corr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_C1:  cal_q.c1 <= cfg_data;
				REG_C2:  cal_q.c2 <= cfg_data;
				REG_C3:  cal_q.c3 <= cfg_data;
				REG_C4:  cal_q.c4 <= cfg_data;
				REG_C5:  cal_q.c5 <= cfg_data;
				REG_C6:  cal_q.c6 <= cfg_data;
				default: ;
			endcase
		end
	end

	bsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal_q),
		.in_valid  (sample_valid),
		.in_en     (front_en),
		.d1        (raw_pressure),
		.d2        (raw_temperature),
		.out_valid (front_valid),
		.out_en    (corr_en),
		.out_data  (front_data)
	);

	bsc_corr u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_en     (corr_en),
		.in_data   (front_data),
		.out_valid (corr_valid),
		.out_en    (press_en),
		.out_data  (corr_data)
	);

	bsc_press u_press (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (corr_valid),
		.in_en       (press_en),
		.in_data     (corr_data),
		.out_valid   (result_valid),
		.out_en      (!result_stall),
		.pressure    (pressure_pa),
		.temperature (temperature_centi)
	);

	assign sample_stall = !front_en;

endmodule
